// ----- hdl/bdd_pkg.sv -----
// Package with shared types and constants of the bumper debounce event detector.
`timescale 1ns / 1ps

package bdd_pkg;

    // Fixed widths of the request fields.
    localparam int RAW_W  = 4;
    localparam int MASK_W = 4;

    // Default sizing, taken up by the top level and its blocks.
    localparam int SWITCH_COUNT_DEF   = 4;
    localparam int HISTORY_LENGTH_DEF = 4;

    typedef enum logic [0:0] {
        EV_PRESSED  = 1'b0,
        EV_RELEASED = 1'b1
    } t_event_kind;

    typedef struct packed {
        logic              posted;
        t_event_kind       kind;
        logic [MASK_W-1:0] mask;
        logic              accepted;
    } t_event_res;

endpackage : bdd_pkg

// ----- hdl/bdd_ifs.sv -----
// Handshake interfaces for the sample and event channels.
`timescale 1ns / 1ps

interface bdd_sample_if;
    logic                     valid;
    logic                     ready;
    logic [bdd_pkg::RAW_W-1:0] raw_switches;
    logic                     sink_ready;

    modport source (output valid, output raw_switches, output sink_ready, input ready);
    modport sink   (input valid, input raw_switches, input sink_ready, output ready);
endinterface : bdd_sample_if

interface bdd_event_if;
    logic                      valid;
    logic                      ready;
    logic                      event_posted;
    logic                      event_kind;
    logic [bdd_pkg::MASK_W-1:0] event_mask;
    logic                      event_accepted;

    modport source (output valid, output event_posted, output event_kind,
                    output event_mask, output event_accepted, input ready);
    modport sink   (input valid, input event_posted, input event_kind,
                    input event_mask, input event_accepted, output ready);
endinterface : bdd_event_if

// ----- hdl/bdd_filter.sv -----
// Per-switch shift histories and debounced stable levels.
`timescale 1ns / 1ps

module bdd_filter #(
    parameter int SWITCH_COUNT   = bdd_pkg::SWITCH_COUNT_DEF,
    parameter int HISTORY_LENGTH = bdd_pkg::HISTORY_LENGTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  logic [SWITCH_COUNT-1:0] i_raw,
    output logic                    o_started,
    output logic [SWITCH_COUNT-1:0] o_pressed,
    output logic [SWITCH_COUNT-1:0] o_released
);
    import bdd_pkg::*;

    logic                      r_started;
    logic [SWITCH_COUNT-1:0]   r_stable;
    logic [HISTORY_LENGTH-1:0] r_hist [SWITCH_COUNT];
    logic [HISTORY_LENGTH-1:0] n_hist [SWITCH_COUNT];

    always_comb begin
        for (int i = 0; i < SWITCH_COUNT; i++) begin
            n_hist[i]     = {r_hist[i][HISTORY_LENGTH-2:0], i_raw[i]};
            o_pressed[i]  = (&n_hist[i]) & ~r_stable[i];
            o_released[i] = ~(|n_hist[i]) & r_stable[i];
        end
    end

    assign o_started = r_started;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_stable  <= '0;
            for (int i = 0; i < SWITCH_COUNT; i++) begin
                r_hist[i] <= '0;
            end
        end else if (i_step) begin
            if (!r_started) begin
                // The first sample seeds every history to agree with it.
                r_started <= 1'b1;
                r_stable  <= i_raw;
                for (int i = 0; i < SWITCH_COUNT; i++) begin
                    r_hist[i] <= {HISTORY_LENGTH{i_raw[i]}};
                end
            end else begin
                r_stable <= (r_stable | o_pressed) & ~o_released;
                for (int i = 0; i < SWITCH_COUNT; i++) begin
                    r_hist[i] <= n_hist[i];
                end
            end
        end
    end

endmodule : bdd_filter

// ----- hdl/bdd_poster.sv -----
// Pending event masks and selection of the event offered to the sink.
`timescale 1ns / 1ps

module bdd_poster #(
    parameter int SWITCH_COUNT = bdd_pkg::SWITCH_COUNT_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  logic                    i_started,
    input  logic [SWITCH_COUNT-1:0] i_pressed,
    input  logic [SWITCH_COUNT-1:0] i_released,
    input  logic                    i_sink_ready,
    output logic                    o_busy,
    output bdd_pkg::t_event_res     o_res
);
    import bdd_pkg::*;

    logic [SWITCH_COUNT-1:0]        r_pend_p;
    logic [SWITCH_COUNT-1:0]        r_pend_r;
    logic [SWITCH_COUNT-1:0]        n_pend_p;
    logic [SWITCH_COUNT-1:0]        n_pend_r;
    logic [SWITCH_COUNT-1:0]        w_sel;
    logic [SWITCH_COUNT+MASK_W-1:0] w_sel_ext;
    logic                           w_post;
    t_event_kind                    w_kind;

    assign o_busy = (|r_pend_p) | (|r_pend_r);

    always_comb begin
        n_pend_p = r_pend_p;
        n_pend_r = r_pend_r;
        w_post   = 1'b0;
        w_kind   = EV_PRESSED;
        w_sel    = '0;
        if (|r_pend_p) begin
            // A retry ignores the sample; pressed goes before released.
            w_post = 1'b1;
            w_sel  = r_pend_p;
            if (i_sink_ready) begin
                n_pend_p = '0;
            end
        end else if (|r_pend_r) begin
            w_post = 1'b1;
            w_kind = EV_RELEASED;
            w_sel  = r_pend_r;
            if (i_sink_ready) begin
                n_pend_r = '0;
            end
        end else if (i_started) begin
            if (|i_pressed) begin
                // Releases in the same sample wait behind the pressed event.
                w_post   = 1'b1;
                w_sel    = i_pressed;
                n_pend_r = i_released;
                n_pend_p = i_sink_ready ? '0 : i_pressed;
            end else if (|i_released) begin
                w_post   = 1'b1;
                w_kind   = EV_RELEASED;
                w_sel    = i_released;
                n_pend_r = i_sink_ready ? '0 : i_released;
            end
        end
    end

    assign w_sel_ext = {{MASK_W{1'b0}}, w_sel};

    always_comb begin
        o_res          = '0;
        o_res.posted   = w_post;
        o_res.kind     = w_kind;
        o_res.mask     = w_sel_ext[MASK_W-1:0];
        o_res.accepted = w_post & i_sink_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_p <= '0;
            r_pend_r <= '0;
        end else if (i_step) begin
            r_pend_p <= n_pend_p;
            r_pend_r <= n_pend_r;
        end
    end

endmodule : bdd_poster

// ----- hdl/bumper_debounce_event_detector_unit.sv -----
// Top level of the bumper debounce event detector.
`timescale 1ns / 1ps
//
// Usage: each request on i_sample carries one sample of the raw switch
// levels and a flag that says whether the event sink takes a post now.
// Every accepted request yields exactly one request on o_event, in order.
// It reports whether an event was offered, its kind (pressed or released),
// the switch mask and whether the sink took it. No event gives all zeros.
// A switch changes its debounced level only after HISTORY_LENGTH equal
// samples. While a refused or deferred mask is pending, requests retry it
// and their samples are dropped.
// Timing: a request is held in an input register, worked on from there and
// lands in the result register, from which o_event offers it. The block
// takes one request every cycle while the receiver does not stall; the
// held request leaves the input register as the debounce state and the
// result register advance.
// Reset clears the pipeline, the pending masks and the started flag; the
// first sample after reset seeds the histories and posts nothing.
// When the receiver stalls, the result register holds its request and the
// input register takes one more request before i_sample.ready drops.
//
module bumper_debounce_event_detector_unit #(
    parameter int SWITCH_COUNT   = bdd_pkg::SWITCH_COUNT_DEF,
    parameter int HISTORY_LENGTH = bdd_pkg::HISTORY_LENGTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bdd_sample_if.sink   i_sample,
    bdd_event_if.source  o_event
);
    import bdd_pkg::*;

    // Input register stage.
    logic             r_in_valid;
    logic [RAW_W-1:0] r_in_raw;
    logic             r_in_sink_ready;

    // Result register stage.
    logic       r_out_valid;
    t_event_res r_out;

    logic                          w_advance;
    logic                          w_busy;
    logic                          w_started;
    logic [SWITCH_COUNT-1:0]       w_pressed;
    logic [SWITCH_COUNT-1:0]       w_released;
    logic [SWITCH_COUNT+RAW_W-1:0] w_raw_ext;
    logic [SWITCH_COUNT-1:0]       w_raw;
    t_event_res                    w_res;

    // The held sample moves on when the result register is empty or drains.
    assign w_advance      = r_in_valid & (~r_out_valid | o_event.ready);
    assign i_sample.ready = ~r_in_valid | w_advance;

    // Switches beyond the raw field read as released.
    assign w_raw_ext = {{SWITCH_COUNT{1'b0}}, r_in_raw};
    assign w_raw     = w_raw_ext[SWITCH_COUNT-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_sample.ready) begin
            r_in_valid <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.ready && i_sample.valid) begin
            r_in_raw        <= i_sample.raw_switches;
            r_in_sink_ready <= i_sample.sink_ready;
        end
    end

    // The filter only sees samples while no mask waits for a retry.
    bdd_filter #(
        .SWITCH_COUNT   (SWITCH_COUNT),
        .HISTORY_LENGTH (HISTORY_LENGTH)
    ) u_filter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_advance & ~w_busy),
        .i_raw      (w_raw),
        .o_started  (w_started),
        .o_pressed  (w_pressed),
        .o_released (w_released)
    );

    bdd_poster #(
        .SWITCH_COUNT (SWITCH_COUNT)
    ) u_poster (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_advance),
        .i_started    (w_started),
        .i_pressed    (w_pressed),
        .i_released   (w_released),
        .i_sink_ready (r_in_sink_ready),
        .o_busy       (w_busy),
        .o_res        (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_event.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_res;
        end
    end

    assign o_event.valid          = r_out_valid;
    assign o_event.event_posted   = r_out.posted;
    assign o_event.event_kind     = logic'(r_out.kind);
    assign o_event.event_mask     = r_out.mask;
    assign o_event.event_accepted = r_out.accepted;

    // An empty result register never blocks the input side.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_sample.ready)
        else $error("input stalled with an empty result register");

    // A request with no event carries an all-zero payload.
    a_idle_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_event.valid && !o_event.event_posted) |->
        (o_event.event_mask == '0 && !o_event.event_kind && !o_event.event_accepted))
        else $error("event fields set without a post");

    // An offered event reports a nonempty mask unless SWITCH_COUNT exceeds MASK_W.
    a_accept_needs_post: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_event.valid && o_event.event_posted) |->
        (o_event.event_mask != '0 || SWITCH_COUNT > MASK_W))
        else $error("posted event with empty mask");

    // A refused post leaves a pending mask for the next request.
    a_refused_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_res.posted && !w_res.accepted) |=> w_busy)
        else $error("refused post was dropped");

    // The filter's started flag never drops while a retry is due.
    a_retry_holds_filter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_busy && w_started) |=> w_started)
        else $error("filter restarted during a retry");

endmodule : bumper_debounce_event_detector_unit

// ----- verif/testbench.sv -----
// Self-checking testbench for the bumper debounce event detector unit.
`timescale 1ns / 1ps

module testbench;
    import bdd_pkg::*;

    localparam int SWITCHES   = SWITCH_COUNT_DEF;
    localparam int HIST_LEN   = HISTORY_LENGTH_DEF;
    localparam int ITEM_TOTAL = 850;
    // Upper bound on cycles from reset release until every event has come back.
    localparam int DRAIN_LIMIT = 60000;
    localparam logic [MASK_W-1:0] SWITCH_SEL = MASK_W'((1 << SWITCHES) - 1);

    // One sample request as queued for the driver.
    typedef struct {
        logic [RAW_W-1:0] raw;
        logic             take;
        int unsigned      phase;
        bit               drain;
    } t_sample_item;

    // Idle percentages per phase. The sender idles lightly while the receiver
    // stalls hard, then the reverse, then both run flat out.
    int unsigned gap_pct   [3] = '{15, 45, 0};
    int unsigned stall_pct [3] = '{45, 15, 0};

    logic i_clk;
    logic i_rst_n;

    bdd_sample_if sample_ch ();
    bdd_event_if  event_ch ();

    bumper_debounce_event_detector_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_ch.sink),
        .o_event  (event_ch.source)
    );

    t_sample_item sample_backlog [$];
    t_event_res   predicted_events [$];
    bit           sample_pending = 1'b0;
    int unsigned  stall_phase = 0;
    int unsigned  fail_count = 0;

    // Debounce state as the predictor sees it.
    bit                deb_started = 1'b0;
    logic [MASK_W-1:0] deb_levels = '0;
    logic [MASK_W-1:0] deb_press_pend = '0;
    logic [MASK_W-1:0] deb_release_pend = '0;
    logic [HIST_LEN-1:0] deb_hist [SWITCHES] = '{default: '0};

    // Advances the debounce state by one sample and returns the event request
    // that the block must produce for it.
    function automatic t_event_res debounce_step(input logic [RAW_W-1:0] raw,
                                                 input logic take);
        t_event_res          res;
        logic [MASK_W-1:0]   lvl;
        logic [MASK_W-1:0]   rose;
        logic [MASK_W-1:0]   fell;
        logic [HIST_LEN-1:0] h;
        res  = '0;
        lvl  = MASK_W'(raw) & SWITCH_SEL;
        rose = '0;
        fell = '0;
        // A pending mask is retried first and the sample is dropped untouched.
        if (deb_press_pend != '0 || deb_release_pend != '0) begin
            res.posted   = 1'b1;
            res.accepted = take;
            if (deb_press_pend != '0) begin
                res.kind = EV_PRESSED;
                res.mask = deb_press_pend;
                if (take) deb_press_pend = '0;
            end else begin
                res.kind = EV_RELEASED;
                res.mask = deb_release_pend;
                if (take) deb_release_pend = '0;
            end
            return res;
        end
        // The first sample after reset seeds levels and histories silently.
        if (!deb_started) begin
            deb_started = 1'b1;
            deb_levels  = lvl;
            for (int i = 0; i < SWITCHES; i++) deb_hist[i] = {HIST_LEN{lvl[i]}};
            return res;
        end
        for (int i = 0; i < SWITCHES; i++) begin
            h = {deb_hist[i][HIST_LEN-2:0], lvl[i]};
            deb_hist[i] = h;
            if (&h && !deb_levels[i]) begin
                deb_levels[i] = 1'b1;
                rose[i]       = 1'b1;
            end else if (h == '0 && deb_levels[i]) begin
                deb_levels[i] = 1'b0;
                fell[i]       = 1'b1;
            end
        end
        // Releases that coincide with presses wait behind the pressed event.
        deb_release_pend |= fell;
        if (rose != '0) begin
            deb_press_pend |= rose;
            res.posted   = 1'b1;
            res.kind     = EV_PRESSED;
            res.mask     = deb_press_pend;
            res.accepted = take;
            if (take) deb_press_pend = '0;
        end else if (fell != '0) begin
            res.posted   = 1'b1;
            res.kind     = EV_RELEASED;
            res.mask     = deb_release_pend;
            res.accepted = take;
            if (take) deb_release_pend = '0;
        end
        return res;
    endfunction

    // Queues one sample; the idle phase follows from its position in the run.
    task automatic add_sample(input logic [RAW_W-1:0] raw, input logic take,
                              input bit drain);
        t_sample_item item;
        item.raw   = raw;
        item.take  = take;
        item.drain = drain;
        if (sample_backlog.size() < ITEM_TOTAL / 3)
            item.phase = 0;
        else if (sample_backlog.size() < 2 * ITEM_TOTAL / 3)
            item.phase = 1;
        else
            item.phase = 2;
        sample_backlog.push_back(item);
    endtask

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Sample driver: presents queued requests with random gaps. A request
    // flagged for draining is held back until every predicted event is in.
    always @(posedge i_clk) begin : sample_driver
        t_sample_item nxt;
        bit           go;
        bit           just_taken;
        if (!i_rst_n) begin
            sample_ch.valid <= 1'b0;
        end else begin
            just_taken = sample_ch.valid && sample_ch.ready;
            if (just_taken) sample_pending = 1'b0;
            go = 1'b0;
            if (!sample_pending && sample_backlog.size() != 0) begin
                go = $urandom_range(99) >= gap_pct[sample_backlog[0].phase];
                if (sample_backlog[0].drain && (just_taken || predicted_events.size() != 0))
                    go = 1'b0;
            end
            if (go) begin
                nxt = sample_backlog.pop_front();
                sample_pending = 1'b1;
                sample_ch.raw_switches <= nxt.raw;
                sample_ch.sink_ready   <= nxt.take;
                stall_phase            <= nxt.phase;
            end else if (!sample_pending) begin
                // Junk on the payload while idle must be ignored by the block.
                sample_ch.raw_switches <= RAW_W'($urandom);
                sample_ch.sink_ready   <= 1'($urandom);
            end
            sample_ch.valid <= sample_pending;
        end
    end

    // Event monitor: predicts on every accepted sample and checks every
    // accepted event request against the oldest prediction.
    always @(posedge i_clk) begin : event_monitor
        t_event_res want;
        if (!i_rst_n) begin
            event_ch.ready <= 1'b0;
        end else begin
            if (sample_ch.valid && sample_ch.ready)
                predicted_events.push_back(debounce_step(sample_ch.raw_switches,
                                                         sample_ch.sink_ready));
            if (event_ch.valid && event_ch.ready) begin
                if (predicted_events.size() == 0) begin
                    $error("event request arrived with no sample waiting for it");
                    fail_count++;
                end else begin
                    want = predicted_events.pop_front();
                    if (event_ch.event_posted !== want.posted) begin
                        $error("event_posted: expected %0d, got %0d",
                               want.posted, event_ch.event_posted);
                        fail_count++;
                    end
                    if (event_ch.event_kind !== want.kind) begin
                        $error("event_kind: expected %0d, got %0d",
                               want.kind, event_ch.event_kind);
                        fail_count++;
                    end
                    if (event_ch.event_mask !== want.mask) begin
                        $error("event_mask: expected %h, got %h",
                               want.mask, event_ch.event_mask);
                        fail_count++;
                    end
                    if (event_ch.event_accepted !== want.accepted) begin
                        $error("event_accepted: expected %0d, got %0d",
                               want.accepted, event_ch.event_accepted);
                        fail_count++;
                    end
                end
            end
            event_ch.ready <= $urandom_range(99) >= stall_pct[stall_phase];
        end
    end

    initial begin : stimulus
        int unsigned      hold;
        int unsigned      waited;
        logic [RAW_W-1:0] target;
        i_rst_n                = 1'b0;
        sample_ch.valid        = 1'b0;
        sample_ch.raw_switches = '0;
        sample_ch.sink_ready   = 1'b0;
        event_ch.ready         = 1'b0;

        // First sample after reset seeds the state and posts nothing.
        add_sample(4'b1010, 1'b1, 1'b0);
        // Four samples of the complement press two switches and release the
        // other two at once; the post is refused, then refused again on retry.
        repeat (3) add_sample(4'b0101, 1'b1, 1'b0);
        add_sample(4'b0101, 1'b0, 1'b0);
        add_sample(4'b1111, 1'b0, 1'b0);
        add_sample(4'b1111, 1'b1, 1'b0);
        // The deferred release is refused once and then taken.
        add_sample(4'b0000, 1'b0, 1'b0);
        add_sample(4'b0000, 1'b1, 1'b0);
        // Plain release with no press in the same sample; the sender first
        // waits for everything outstanding to come back.
        add_sample(4'b0000, 1'b1, 1'b1);
        repeat (3) add_sample(4'b0000, 1'b1, 1'b0);
        // All switches pressed together, then all released together.
        repeat (4) add_sample(4'b1111, 1'b1, 1'b0);
        repeat (4) add_sample(4'b0000, 1'b1, 1'b0);
        // Bouncing input never settles, so no event comes out.
        add_sample(4'b1111, 1'b1, 1'b0);
        add_sample(4'b0000, 1'b0, 1'b0);
        add_sample(4'b1111, 1'b1, 1'b0);

        // Mostly held patterns long enough to debounce, with some short
        // bounces and stretches of pure noise in between.
        while (sample_backlog.size() < ITEM_TOTAL) begin
            if ($urandom_range(99) < 80) begin
                target = RAW_W'($urandom);
                hold   = ($urandom_range(99) < 80) ? $urandom_range(4, 7)
                                                    : $urandom_range(1, 3);
                add_sample(target, $urandom_range(99) < 70, $urandom_range(39) == 0);
                repeat (hold - 1) add_sample(target, $urandom_range(99) < 70, 1'b0);
            end else begin
                repeat ($urandom_range(1, 4))
                    add_sample(RAW_W'($urandom), 1'($urandom), 1'b0);
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        waited = 0;
        while ((sample_backlog.size() != 0 || sample_pending || predicted_events.size() != 0)
               && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end

        if (sample_backlog.size() != 0 || sample_pending || predicted_events.size() != 0) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            // Let any stray request past the last expected one show up, and
            // let the last prediction drain if it was queued on the final edge.
            repeat (10) @(posedge i_clk);
            if (fail_count == 0 && predicted_events.size() == 0)
                $display("TEST PASSED");
            else
                $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : watchdog
        #400000;
        $display("TEST FAILED");
        $finish;
    end

endmodule : testbench

// ----- files.f -----
hdl/bdd_pkg.sv
hdl/bdd_ifs.sv
hdl/bdd_filter.sv
hdl/bdd_poster.sv
hdl/bumper_debounce_event_detector_unit.sv
verif/testbench.sv
